// ----- rtl/utm_to_grid_reference_string_core_defines.svh -----
// ----------------------------------------------------------------------------
// utm_to_grid_reference_string_core_defines
// Assertion macros shared by the grid reference encoder modules.
// ----------------------------------------------------------------------------
`ifndef UTM_TO_GRID_REFERENCE_STRING_CORE_DEFINES_SVH
`define UTM_TO_GRID_REFERENCE_STRING_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define UTG_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define UTG_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/utg_pkg.sv -----
// ----------------------------------------------------------------------------
// utg_pkg
// Types, constants and helper functions of the grid reference encoder.
// ----------------------------------------------------------------------------
package utg_pkg;

    localparam int LAT_W   = 28;
    localparam int LON_W   = 29;
    localparam int NORTH_W = 24;
    localparam int EAST_W  = 20;
    localparam int CHAR_W  = 8;
    localparam int STAT_W  = 2;
    localparam int PREC_W  = 3;
    localparam int REM_W   = 17;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [STAT_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_LAT_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_EAST_LOW  = 2'd2;

    localparam logic [PREC_W-1:0] PREC_RESET = 3'd5;
    localparam logic [PREC_W-1:0] PREC_MIN   = 3'd2;
    localparam logic [PREC_W-1:0] PREC_MAX   = 3'd5;

    localparam int LAT_LIMIT_UDEG   = 90000000;
    localparam int BAND_X_LO_UDEG   = 72000000;
    localparam int BAND_X_HI_UDEG   = 84000000;
    localparam int BAND_OFFSET_UDEG = 96000000;
    localparam int LON_HALF_UDEG    = 180000000;
    localparam int LON_FULL_UDEG    = 360000000;

    // zone width 6 deg = 2^7 * 46875 udeg, band height 8 deg = 2^9 * 15625 udeg
    localparam int ZONE_STEP        = 46875;
    localparam int ZONE_RECIP       = 89;
    localparam int ZONE_RECIP_SHIFT = 22;
    localparam int BAND_STEP        = 15625;
    localparam int BAND_RECIP       = 33;
    localparam int BAND_RECIP_SHIFT = 19;
    // 100 km = 2^5 * 3125 m
    localparam int SQUARE_M         = 100000;
    localparam int SQUARE_RECIP     = 671;
    localparam int SQUARE_SHIFT     = 21;
    localparam int ZONE_COUNT       = 60;
    localparam int EAST_WRAP_SQ     = 10;

    localparam int BAND_X_IDX    = 21;
    localparam int BAND_LAST_IDX = 23;
    localparam int LETTER_COUNT  = 24;
    localparam int ROW_COUNT     = 20;
    localparam int ROW_EVEN_ADD  = 5;
    localparam int COL_ZONE_ADD  = 8;

    localparam int DIGIT_STEP  = 10000;
    localparam int DIGIT_RADIX = 10;

    localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_BAD  = 8'h3F;
    localparam logic [CHAR_W-1:0] CHAR_NONE = 8'h00;

    localparam logic [8*24-1:0] LETTERS = "ABCDEFGHJKLMNPQRSTUVWXYZ";

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [5:0]        zone;
        logic [4:0]        band;
        logic [4:0]        col;
        logic [4:0]        row;
        logic [REM_W-1:0]  east_rem;
        logic [REM_W-1:0]  north_rem;
    } job_t;

    function automatic logic [CHAR_W-1:0] letter(input logic [4:0] idx);
        logic [CHAR_W-1:0] ch;
        ch = CHAR_BAD;
        for (int k = 0; k < LETTER_COUNT; k++) begin
            if (idx == 5'(k)) begin
                ch = LETTERS[8*(LETTER_COUNT-1-k) +: 8];
            end
        end
        return ch;
    endfunction

    function automatic logic [4:0] mod20(input logic [7:0] v);
        logic [7:0] t;
        t = v;
        if (t >= 8'd160) t = t - 8'd160;
        if (t >= 8'd80)  t = t - 8'd80;
        if (t >= 8'd40)  t = t - 8'd40;
        if (t >= 8'd20)  t = t - 8'd20;
        return t[4:0];
    endfunction

    function automatic logic [1:0] mod3(input logic [5:0] v);
        logic [5:0] t;
        t = v;
        if (t >= 6'd48) t = t - 6'd48;
        if (t >= 6'd24) t = t - 6'd24;
        if (t >= 6'd12) t = t - 6'd12;
        if (t >= 6'd6)  t = t - 6'd6;
        if (t >= 6'd3)  t = t - 6'd3;
        return t[1:0];
    endfunction

    function automatic logic [2:0] zone_tens(input logic [5:0] z);
        logic [2:0] n;
        n = '0;
        for (int k = 1; k <= 6; k++) begin
            if (z >= 6'(10 * k)) n = n + 3'd1;
        end
        return n;
    endfunction

    function automatic logic [3:0] lead_digit(input logic [REM_W-1:0] r);
        logic [3:0] n;
        n = '0;
        for (int k = 1; k <= 9; k++) begin
            if (r >= REM_W'(DIGIT_STEP * k)) n = n + 4'd1;
        end
        return n;
    endfunction

endpackage

// ----- rtl/utg_front.sv -----
// ----------------------------------------------------------------------------
// utg_front
// Six-stage front pipeline: range checks, zone, band and 100 km square
// arithmetic, producing one job record per accepted position.
// ----------------------------------------------------------------------------
`include "utm_to_grid_reference_string_core_defines.svh"

module utg_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [utg_pkg::LAT_W-1:0]    latitude_udeg,
    input  logic signed [utg_pkg::LON_W-1:0]    longitude_udeg,
    input  logic        [utg_pkg::NORTH_W-1:0]  northing_m,
    input  logic        [utg_pkg::EAST_W-1:0]   easting_m,
    output logic                                job_valid,
    input  logic                                job_ready,
    output utg_pkg::job_t                       job
);

    logic       adv;
    logic [5:0] v_reg;

    // stage 1: input capture
    logic signed [utg_pkg::LAT_W-1:0]   lat_p1_reg;
    logic signed [utg_pkg::LON_W-1:0]   lon_p1_reg;
    logic        [utg_pkg::NORTH_W-1:0] north_p1_reg;
    logic        [utg_pkg::EAST_W-1:0]  east_p1_reg;

    // stage 2: wrap and offset
    logic signed [29:0] lon_ext, lon_wrap, lon_off;
    logic signed [28:0] lat_off;
    logic               lat_bad_p2_next, band_x_p2_next;
    logic               lat_bad_p2_reg, band_x_p2_reg;
    logic [21:0]        y_p2_reg;
    logic [18:0]        zb_p2_reg;
    logic [utg_pkg::NORTH_W-1:0] north_p2_reg;
    logic [utg_pkg::EAST_W-1:0]  east_p2_reg;

    // stage 3: quotient estimates
    logic [28:0] prod_z, prod_n;
    logic [24:0] prod_b, prod_e;
    logic        lat_bad_p3_reg, band_x_p3_reg;
    logic [21:0] y_p3_reg;
    logic [18:0] zb_p3_reg;
    logic [utg_pkg::NORTH_W-1:0] north_p3_reg;
    logic [utg_pkg::EAST_W-1:0]  east_p3_reg;
    logic [5:0]  qz_p3_reg;
    logic [4:0]  qb_p3_reg;
    logic [7:0]  qn_p3_reg;
    logic [3:0]  qe_p3_reg;

    // stage 4: back products
    logic        lat_bad_p4_reg, band_x_p4_reg;
    logic [21:0] y_p4_reg, pz_p4_reg;
    logic [18:0] zb_p4_reg, pb_p4_reg;
    logic [utg_pkg::NORTH_W-1:0] north_p4_reg, pn_p4_reg;
    logic [utg_pkg::EAST_W-1:0]  east_p4_reg, pe_p4_reg;
    logic [5:0]  qz_p4_reg;
    logic [4:0]  qb_p4_reg;
    logic [7:0]  qn_p4_reg;
    logic [3:0]  qe_p4_reg;

    // stage 5: remainder correction
    logic [21:0] rz;
    logic [18:0] rb;
    logic [utg_pkg::NORTH_W-1:0] rn;
    logic [utg_pkg::EAST_W-1:0]  re;
    logic        lat_bad_p5_reg, band_x_p5_reg;
    logic [5:0]  qz_p5_reg;
    logic [4:0]  qb_p5_reg;
    logic [7:0]  qn_p5_reg;
    logic [3:0]  qe_p5_reg;
    logic [utg_pkg::REM_W-1:0] er_p5_reg, nr_p5_reg;
    logic [5:0]  qz_p5_next;
    logic [4:0]  qb_p5_next;
    logic [7:0]  qn_p5_next;
    logic [3:0]  qe_p5_next;
    logic [utg_pkg::REM_W-1:0] er_p5_next, nr_p5_next;

    // stage 6: job assembly
    utg_pkg::job_t job_next, job_reg;
    logic [5:0] zone;
    logic [3:0] scol;
    logic [4:0] row_sum;
    logic [5:0] col_sum;
    logic [1:0] zone_m3;

    assign adv       = !v_reg[5] || job_ready;
    assign in_ready  = adv;
    assign job_valid = v_reg[5];
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (adv) begin
            v_reg <= {v_reg[4:0], in_valid};
        end
    end

    always_comb begin
        lon_ext = $signed({lon_p1_reg[utg_pkg::LON_W-1], lon_p1_reg});
        if (lon_ext >= 30'(utg_pkg::LON_HALF_UDEG)) begin
            lon_wrap = lon_ext - 30'(utg_pkg::LON_FULL_UDEG);
        end else if (lon_ext < -30'(utg_pkg::LON_HALF_UDEG)) begin
            lon_wrap = lon_ext + 30'(utg_pkg::LON_FULL_UDEG);
        end else begin
            lon_wrap = lon_ext;
        end
        lon_off = lon_wrap + 30'(utg_pkg::LON_HALF_UDEG);
        lat_off = $signed({lat_p1_reg[utg_pkg::LAT_W-1], lat_p1_reg})
                  + 29'(utg_pkg::BAND_OFFSET_UDEG);
        lat_bad_p2_next = (lat_p1_reg < 28'(-utg_pkg::LAT_LIMIT_UDEG))
                       || (lat_p1_reg > 28'(utg_pkg::LAT_LIMIT_UDEG));
        band_x_p2_next  = (lat_p1_reg >= 28'(utg_pkg::BAND_X_LO_UDEG))
                       && (lat_p1_reg <= 28'(utg_pkg::BAND_X_HI_UDEG));
    end

    always_comb begin
        prod_z = 29'(y_p2_reg) * 29'(utg_pkg::ZONE_RECIP);
        prod_b = 25'(zb_p2_reg) * 25'(utg_pkg::BAND_RECIP);
        prod_n = 29'(north_p2_reg[utg_pkg::NORTH_W-1:5]) * 29'(utg_pkg::SQUARE_RECIP);
        prod_e = 25'(east_p2_reg[utg_pkg::EAST_W-1:5]) * 25'(utg_pkg::SQUARE_RECIP);
    end

    always_comb begin
        rz = y_p4_reg - pz_p4_reg;
        rb = zb_p4_reg - pb_p4_reg;
        rn = north_p4_reg - pn_p4_reg;
        re = east_p4_reg - pe_p4_reg;
        qz_p5_next = qz_p4_reg;
        qb_p5_next = qb_p4_reg;
        qn_p5_next = qn_p4_reg;
        qe_p5_next = qe_p4_reg;
        nr_p5_next = rn[utg_pkg::REM_W-1:0];
        er_p5_next = re[utg_pkg::REM_W-1:0];
        if (rz >= 22'(utg_pkg::ZONE_STEP)) qz_p5_next = qz_p4_reg + 6'd1;
        if (rb >= 19'(utg_pkg::BAND_STEP)) qb_p5_next = qb_p4_reg + 5'd1;
        if (rn >= 24'(utg_pkg::SQUARE_M)) begin
            qn_p5_next = qn_p4_reg + 8'd1;
            nr_p5_next = 17'(rn - 24'(utg_pkg::SQUARE_M));
        end
        if (re >= 20'(utg_pkg::SQUARE_M)) begin
            qe_p5_next = qe_p4_reg + 4'd1;
            er_p5_next = 17'(re - 20'(utg_pkg::SQUARE_M));
        end
    end

    always_comb begin
        zone    = 6'(utg_pkg::ZONE_COUNT) - qz_p5_reg;
        scol    = (qe_p5_reg == 4'(utg_pkg::EAST_WRAP_SQ)) ? 4'd0 : qe_p5_reg;
        zone_m3 = utg_pkg::mod3(zone - 6'd1);
        row_sum = utg_pkg::mod20(qn_p5_reg)
                  + (zone[0] ? 5'd0 : 5'(utg_pkg::ROW_EVEN_ADD));
        if (row_sum >= 5'(utg_pkg::ROW_COUNT)) row_sum = row_sum - 5'(utg_pkg::ROW_COUNT);
        col_sum = 6'(scol) - 6'd1 + 6'(zone_m3) * 6'(utg_pkg::COL_ZONE_ADD);
        if (col_sum >= 6'(utg_pkg::LETTER_COUNT)) begin
            col_sum = col_sum - 6'(utg_pkg::LETTER_COUNT);
        end

        job_next.zone      = zone;
        job_next.row       = row_sum;
        job_next.col       = col_sum[4:0];
        job_next.east_rem  = er_p5_reg;
        job_next.north_rem = nr_p5_reg;
        if (band_x_p5_reg) begin
            job_next.band = 5'(utg_pkg::BAND_X_IDX);
        end else if (qb_p5_reg > 5'(utg_pkg::BAND_LAST_IDX)) begin
            job_next.band = 5'(utg_pkg::BAND_LAST_IDX);
        end else begin
            job_next.band = qb_p5_reg;
        end
        if (lat_bad_p5_reg) begin
            job_next.status = utg_pkg::STATUS_LAT_RANGE;
        end else if (scol == 4'd0) begin
            job_next.status = utg_pkg::STATUS_EAST_LOW;
        end else begin
            job_next.status = utg_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            lat_p1_reg   <= latitude_udeg;
            lon_p1_reg   <= longitude_udeg;
            north_p1_reg <= northing_m;
            east_p1_reg  <= easting_m;

            lat_bad_p2_reg <= lat_bad_p2_next;
            band_x_p2_reg  <= band_x_p2_next;
            y_p2_reg       <= lon_off[28:7];
            zb_p2_reg      <= lat_off[27:9];
            north_p2_reg   <= north_p1_reg;
            east_p2_reg    <= east_p1_reg;

            lat_bad_p3_reg <= lat_bad_p2_reg;
            band_x_p3_reg  <= band_x_p2_reg;
            y_p3_reg       <= y_p2_reg;
            zb_p3_reg      <= zb_p2_reg;
            north_p3_reg   <= north_p2_reg;
            east_p3_reg    <= east_p2_reg;
            qz_p3_reg      <= prod_z[utg_pkg::ZONE_RECIP_SHIFT +: 6];
            qb_p3_reg      <= prod_b[utg_pkg::BAND_RECIP_SHIFT +: 5];
            qn_p3_reg      <= prod_n[utg_pkg::SQUARE_SHIFT +: 8];
            qe_p3_reg      <= prod_e[utg_pkg::SQUARE_SHIFT +: 4];

            lat_bad_p4_reg <= lat_bad_p3_reg;
            band_x_p4_reg  <= band_x_p3_reg;
            y_p4_reg       <= y_p3_reg;
            zb_p4_reg      <= zb_p3_reg;
            north_p4_reg   <= north_p3_reg;
            east_p4_reg    <= east_p3_reg;
            qz_p4_reg      <= qz_p3_reg;
            qb_p4_reg      <= qb_p3_reg;
            qn_p4_reg      <= qn_p3_reg;
            qe_p4_reg      <= qe_p3_reg;
            pz_p4_reg      <= 22'(qz_p3_reg) * 22'(utg_pkg::ZONE_STEP);
            pb_p4_reg      <= 19'(qb_p3_reg) * 19'(utg_pkg::BAND_STEP);
            pn_p4_reg      <= 24'(qn_p3_reg) * 24'(utg_pkg::SQUARE_M);
            pe_p4_reg      <= 20'(qe_p3_reg) * 20'(utg_pkg::SQUARE_M);

            lat_bad_p5_reg <= lat_bad_p4_reg;
            band_x_p5_reg  <= band_x_p4_reg;
            qz_p5_reg      <= qz_p5_next;
            qb_p5_reg      <= qb_p5_next;
            qn_p5_reg      <= qn_p5_next;
            qe_p5_reg      <= qe_p5_next;
            er_p5_reg      <= er_p5_next;
            nr_p5_reg      <= nr_p5_next;

            job_reg <= job_next;
        end
    end

    `UTG_ASSERT_IMP(a_job_fields, aclk, aresetn,
        job_valid && job.status == utg_pkg::STATUS_OK,
        job.zone >= 6'd1 && job.zone <= 6'd60 && job.band <= 5'd23 && job.col <= 5'd23 && job.row <= 5'd19,
        "front: ok job carries an index out of range")

endmodule

// ----- rtl/utg_queue.sv -----
// ----------------------------------------------------------------------------
// utg_queue
// Short job queue between the front pipeline and the character serializer.
// ----------------------------------------------------------------------------
`include "utm_to_grid_reference_string_core_defines.svh"

module utg_queue #(
    parameter int DEPTH = utg_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  utg_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_pop,
    output utg_pkg::job_t out_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    utg_pkg::job_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg, wr_ptr_next, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          push;

    assign in_ready  = count_reg != CW'(DEPTH);
    assign out_valid = count_reg != '0;
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (out_pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (push && !out_pop) begin
            count_next = count_reg + CW'(1);
        end else if (!push && out_pop) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
    end

    `UTG_ASSERT_IMP(a_pop_nonempty, aclk, aresetn, out_pop, count_reg != '0,
        "queue: pop while empty")

endmodule

// ----- rtl/utg_back.sv -----
// ----------------------------------------------------------------------------
// utg_back
// Character serializer: turns one job into the grid reference characters,
// one per cycle while m_tready is high, through a registered output stage.
// ----------------------------------------------------------------------------
`include "utm_to_grid_reference_string_core_defines.svh"

module utg_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [utg_pkg::PREC_W-1:0]       precision_digits,
    input  logic                             job_valid,
    output logic                             job_pop,
    input  utg_pkg::job_t                    job,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [utg_pkg::CHAR_W-1:0]       m_tdata,
    output logic                             m_tlast,
    output logic [utg_pkg::STAT_W-1:0]       m_tuser
);

    localparam logic [3:0] POS_ZONE_TENS = 4'd0;
    localparam logic [3:0] POS_ZONE_ONES = 4'd1;
    localparam logic [3:0] POS_BAND      = 4'd2;
    localparam logic [3:0] POS_COL       = 4'd3;
    localparam logic [3:0] POS_ROW       = 4'd4;

    logic                        busy_reg, busy_next;
    logic [3:0]                  pos_reg, pos_next;
    utg_pkg::job_t               job_reg;
    logic [utg_pkg::REM_W-1:0]   r_reg, r_next, rem, r_step;
    logic                        out_valid_reg;
    logic [utg_pkg::CHAR_W-1:0]  out_char_reg, ch;
    logic                        out_last_reg;
    logic [utg_pkg::STAT_W-1:0]  out_status_reg;

    logic [utg_pkg::PREC_W-1:0]  d;
    logic [3:0]                  last_pos, east_end, dg;
    logic [2:0]                  tens;
    logic                        is_err, is_last, emit;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_status_reg;

    always_comb begin
        if (precision_digits < utg_pkg::PREC_MIN) begin
            d = utg_pkg::PREC_MIN;
        end else if (precision_digits > utg_pkg::PREC_MAX) begin
            d = utg_pkg::PREC_MAX;
        end else begin
            d = precision_digits;
        end
        last_pos = POS_ROW + {d, 1'b0};
        east_end = POS_ROW + {1'b0, d};
        is_err   = job_reg.status != utg_pkg::STATUS_OK;
        is_last  = is_err || pos_reg == last_pos;
        emit     = busy_reg && (!out_valid_reg || m_tready);
        job_pop  = job_valid && (!busy_reg || (emit && is_last));

        dg     = utg_pkg::lead_digit(r_reg);
        rem    = r_reg - 17'(dg) * 17'(utg_pkg::DIGIT_STEP);
        r_step = 17'(rem[13:0]) * 17'(utg_pkg::DIGIT_RADIX);
        tens   = utg_pkg::zone_tens(job_reg.zone);

        case (pos_reg)
            POS_ZONE_TENS: ch = utg_pkg::CHAR_ZERO + 8'(tens);
            POS_ZONE_ONES: ch = utg_pkg::CHAR_ZERO
                                + 8'(job_reg.zone - 6'(tens) * 6'(utg_pkg::DIGIT_RADIX));
            POS_BAND:      ch = utg_pkg::letter(job_reg.band);
            POS_COL:       ch = utg_pkg::letter(job_reg.col);
            POS_ROW:       ch = utg_pkg::letter(job_reg.row);
            default:       ch = utg_pkg::CHAR_ZERO + 8'(dg);
        endcase
        if (is_err) ch = utg_pkg::CHAR_NONE;

        busy_next = busy_reg;
        pos_next  = pos_reg;
        r_next    = r_reg;
        if (job_pop) begin
            busy_next = 1'b1;
            pos_next  = POS_ZONE_TENS;
            r_next    = job.east_rem;
        end else if (emit && is_last) begin
            busy_next = 1'b0;
        end else if (emit) begin
            pos_next = pos_reg + 4'd1;
            if (pos_reg == east_end) begin
                r_next = job_reg.north_rem;
            end else if (pos_reg > POS_ROW) begin
                r_next = r_step;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg      <= 1'b0;
            pos_reg       <= POS_ZONE_TENS;
            out_valid_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            pos_reg  <= pos_next;
            if (emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        r_reg <= r_next;
        if (job_pop) begin
            job_reg <= job;
        end
        if (emit) begin
            out_char_reg   <= ch;
            out_last_reg   <= is_last;
            out_status_reg <= job_reg.status;
        end
    end

    `UTG_ASSERT_IMP(a_err_single, aclk, aresetn,
        m_tvalid && m_tuser != utg_pkg::STATUS_OK,
        m_tlast && m_tdata == utg_pkg::CHAR_NONE,
        "back: error result must be a single zero character")
    `UTG_ASSERT_IMP(a_pos_bound, aclk, aresetn, busy_reg, pos_reg <= 4'd14,
        "back: character position beyond longest string")
    `UTG_ASSERT_NXT(a_idle_after_last, aclk, aresetn, emit && is_last && !job_valid,
        !busy_reg, "back: still busy after last character with empty queue")

endmodule

// ----- rtl/utm_to_grid_reference_string_core.sv -----
// ----------------------------------------------------------------------------
// utm_to_grid_reference_string_core
// Encodes latitude, longitude, UTM northing and easting into a grid
// reference string, one ASCII character per output transfer.
//
//   channel   dir  handshake          payload
//   s_        in   s_tvalid/s_tready  lat, lon, northing, easting in s_tdata
//   m_        out  m_tvalid/m_tready  char in m_tdata, last in m_tlast, status
//   cfg_      in   cfg_valid/cfg_ready precision_digits in cfg_data
//
// A job passes the front pipeline and then waits in a 4-entry queue.
// The serializer emits one character per cycle while m_tready is high;
// 5 + 2*d per position (9 to 15, d = clamped precision_digits), one on error.
// aresetn clears the pipeline, queue and output stage; precision resets to 5.
// m_tready low holds the output register; a full queue drops s_tready.
// ----------------------------------------------------------------------------
module utm_to_grid_reference_string_core #(
    parameter int QUEUE_DEPTH = utg_pkg::QUEUE_DEPTH
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [27:0] latitude_udeg, [56:28] longitude_udeg, [80:57] northing_m,
    // [100:81] easting_m, [103:101] zero
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [7:0] char_code
    output logic [7:0]   m_tdata,
    output logic         m_tlast,
    // [1:0] status
    output logic [1:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_data
);

    logic [utg_pkg::PREC_W-1:0] prec_reg;
    logic                       f_valid, f_ready, q_valid, q_pop;
    utg_pkg::job_t              f_job, q_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prec_reg <= utg_pkg::PREC_RESET;
        end else if (cfg_valid && cfg_ready) begin
            prec_reg <= cfg_data;
        end
    end

    utg_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .latitude_udeg  (s_tdata[27:0]),
        .longitude_udeg (s_tdata[56:28]),
        .northing_m     (s_tdata[80:57]),
        .easting_m      (s_tdata[100:81]),
        .job_valid      (f_valid),
        .job_ready      (f_ready),
        .job            (f_job)
    );

    utg_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_job    (f_job),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_job   (q_job)
    );

    utg_back u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .precision_digits (prec_reg),
        .job_valid        (q_valid),
        .job_pop          (q_pop),
        .job              (q_job),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tlast          (m_tlast),
        .m_tuser          (m_tuser)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid reference string encoder. A table of
// directed positions covers the reset string, latitude and easting errors,
// band edges and longitude wrap. Random positions follow under every
// precision setting. Each accepted position is predicted character by
// character and checked in order against the output stream.
// ----------------------------------------------------------------------------
module tb;

    localparam int    CYCLE_LIMIT  = 1000000;
    localparam int    ASCII_ZERO   = 48;
    localparam int    PHASE_ITEMS  = 30;
    localparam int    DRAIN_CYCLES = 40;
    localparam string GRID_LETTERS = "ABCDEFGHJKLMNPQRSTUVWXYZ";
    localparam string RESET_REF    = "30NWF1234567890";

    typedef enum logic [1:0] {
        ROW_PREDICT,
        ROW_LAT_ERR,
        ROW_EAST_ERR,
        ROW_RESET_REF
    } row_kind_e;

    typedef struct packed {
        logic signed [utg_pkg::LAT_W-1:0] lat;
        logic signed [utg_pkg::LON_W-1:0] lon;
        logic [utg_pkg::NORTH_W-1:0]      north;
        logic [utg_pkg::EAST_W-1:0]       east;
        row_kind_e                        kind;
    } position_row_t;

    typedef struct packed {
        logic [utg_pkg::CHAR_W-1:0] code;
        logic                       last;
        logic [utg_pkg::STAT_W-1:0] status;
    } grid_char_t;

    localparam position_row_t DIRECTED_ROWS [24] = '{
        '{28'sd0, 29'sd0, 24'd4067890, 20'd512345, ROW_RESET_REF},
        '{28'sd90000001, 29'sd0, 24'd0, 20'd500000, ROW_LAT_ERR},
        '{-28'sd90000001, 29'sd0, 24'd0, 20'd500000, ROW_LAT_ERR},
        '{28'sh7FFFFFF, 29'sd1000, 24'd1, 20'd0, ROW_LAT_ERR},
        '{28'sh8000000, -29'sd1000, 24'd2, 20'd99999, ROW_LAT_ERR},
        '{28'sd0, 29'sd0, 24'd0, 20'd99999, ROW_EAST_ERR},
        '{28'sd45000000, 29'sd5000000, 24'd5000000, 20'd0, ROW_EAST_ERR},
        '{-28'sd45000000, -29'sd5000000, 24'd7000000, 20'd1000000, ROW_EAST_ERR},
        '{28'sd1000, 29'sd0, 24'hFFFFFF, 20'hFFFFF, ROW_EAST_ERR},
        '{28'sd90000000, 29'sd180000000, 24'd9999999, 20'd999999, ROW_PREDICT},
        '{-28'sd90000000, -29'sd180000000, 24'd0, 20'd100000, ROW_PREDICT},
        '{28'sd72000000, 29'sd179999999, 24'd123456, 20'd234567, ROW_PREDICT},
        '{28'sd84000000, 29'sd3000000, 24'd8765432, 20'd345678, ROW_PREDICT},
        '{28'sd71999999, -29'sd3000000, 24'd1999999, 20'd456789, ROW_PREDICT},
        '{28'sd84000001, 29'sd60000000, 24'd2000000, 20'd567890, ROW_PREDICT},
        '{28'sd88000000, -29'sd60000000, 24'd3141592, 20'd678901, ROW_PREDICT},
        '{-28'sd80000000, 29'sd90000000, 24'd4000001, 20'd789012, ROW_PREDICT},
        '{-28'sd80000001, -29'sd90000000, 24'd5999999, 20'd890123, ROW_PREDICT},
        '{-28'sd88000001, 29'sd120000000, 24'd6543210, 20'd901234, ROW_PREDICT},
        '{28'sd0, 29'sh0FFFFFFF, 24'hFFFFFF, 20'd987654, ROW_PREDICT},
        '{28'sd0, 29'sh10000000, 24'd2000000, 20'd100000, ROW_PREDICT},
        '{28'sd12345678, 29'sd168000001, 24'd1900000, 20'd899999, ROW_PREDICT},
        '{-28'sd12345678, 29'sd162000001, 24'd1234567, 20'd999999, ROW_PREDICT},
        '{28'sd33000000, -29'sd1, 24'd7654321, 20'd200001, ROW_PREDICT}
    };

    localparam logic [utg_pkg::PREC_W-1:0] PREC_PLAN [8] = '{
        3'd2, 3'd0, 3'd7, 3'd3, 3'd4, 3'd1, 3'd6, 3'd5
    };

    logic                aclk      = 1'b0;
    logic                aresetn   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [103:0]        s_tdata   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [7:0]          m_tdata;
    logic                m_tlast;
    logic [1:0]          m_tuser;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_data  = '0;

    grid_char_t                 pending_chars [$];
    logic [utg_pkg::PREC_W-1:0] prec_mirror   = utg_pkg::PREC_RESET;
    bit                         sender_gaps   = 1'b1;
    int                         fault_count   = 0;
    int                         cycle_count   = 0;

    utm_to_grid_reference_string_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #10 aclk = ~aclk;

    function automatic void predict_grid_ref(
        input logic signed [utg_pkg::LAT_W-1:0] lat,
        input logic signed [utg_pkg::LON_W-1:0] lon,
        input logic [utg_pkg::NORTH_W-1:0]      north,
        input logic [utg_pkg::EAST_W-1:0]       east,
        input logic [utg_pkg::PREC_W-1:0]       prec
    );
        int          digits, zone, band, srow, scol, factor, ev, nv;
        longint      lat_v, lon_v;
        byte unsigned txt [$];
        lat_v  = lat;
        lon_v  = lon;
        digits = int'(prec);
        if (digits < 2) digits = 2;
        if (digits > 5) digits = 5;

        if (lat_v < -longint'(utg_pkg::LAT_LIMIT_UDEG)
                || lat_v > longint'(utg_pkg::LAT_LIMIT_UDEG)) begin
            pending_chars.push_back('{utg_pkg::CHAR_NONE, 1'b1, utg_pkg::STATUS_LAT_RANGE});
            return;
        end
        scol = (int'(east) % 1000000) / 100000;
        if (scol == 0) begin
            pending_chars.push_back('{utg_pkg::CHAR_NONE, 1'b1, utg_pkg::STATUS_EAST_LOW});
            return;
        end

        while (lon_v >= 180000000) lon_v -= 360000000;
        while (lon_v < -180000000) lon_v += 360000000;
        zone = 60 - int'((lon_v + 180000000) / 6000000);

        if (lat_v >= 72000000 && lat_v <= 84000000) begin
            band = 21;
        end else begin
            band = int'((lat_v + 96000000) / 8000000);
        end
        if (band > 23) band = 23;

        srow = (int'(north) % 2000000) / 100000 + 1;
        if (zone % 2 == 0) srow += 5;
        while (srow > 20) srow -= 20;

        case ((zone - 1) % 3)
            1: begin
                scol += 8;
            end
            2: begin
                scol += 16;
            end
            default: begin
            end
        endcase
        while (scol > 24) scol -= 24;

        factor = 10 ** (5 - digits);
        ev = (int'(east) % 100000) / factor;
        nv = (int'(north) % 100000) / factor;

        txt.push_back(8'(ASCII_ZERO + zone / 10));
        txt.push_back(8'(ASCII_ZERO + zone % 10));
        txt.push_back(GRID_LETTERS[band]);
        txt.push_back(GRID_LETTERS[scol - 1]);
        txt.push_back(GRID_LETTERS[srow - 1]);
        for (int i = 0; i < digits; i++) begin
            txt.push_back(8'(ASCII_ZERO + (ev / (10 ** (digits - 1 - i))) % 10));
        end
        for (int i = 0; i < digits; i++) begin
            txt.push_back(8'(ASCII_ZERO + (nv / (10 ** (digits - 1 - i))) % 10));
        end
        for (int k = 0; k < txt.size(); k++) begin
            pending_chars.push_back('{txt[k], k == txt.size() - 1, utg_pkg::STATUS_OK});
        end
    endfunction

    task automatic send_position(
        input logic signed [utg_pkg::LAT_W-1:0] lat,
        input logic signed [utg_pkg::LON_W-1:0] lon,
        input logic [utg_pkg::NORTH_W-1:0]      north,
        input logic [utg_pkg::EAST_W-1:0]       east,
        input row_kind_e                        kind
    );
        int pick, gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = {3'b000, east, north, lon, lat};
        do @(posedge aclk); while (!s_tready);

        case (kind)
            ROW_LAT_ERR: begin
                pending_chars.push_back('{utg_pkg::CHAR_NONE, 1'b1,
                                          utg_pkg::STATUS_LAT_RANGE});
            end
            ROW_EAST_ERR: begin
                pending_chars.push_back('{utg_pkg::CHAR_NONE, 1'b1,
                                          utg_pkg::STATUS_EAST_LOW});
            end
            ROW_RESET_REF: begin
                for (int k = 0; k < RESET_REF.len(); k++) begin
                    pending_chars.push_back('{8'(RESET_REF[k]), k == RESET_REF.len() - 1,
                                              utg_pkg::STATUS_OK});
                end
            end
            default: begin
                predict_grid_ref(lat, lon, north, east, prec_mirror);
            end
        endcase

        // hold valid high when the next transfer follows back to back
        pick = $urandom_range(0, 99);
        if (!sender_gaps || pick < 55) gap = 0;
        else if (pick < 90) gap = $urandom_range(1, 3);
        else if (pick < 98) gap = $urandom_range(4, 12);
        else gap = $urandom_range(20, 60);
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic send_random_position();
        logic signed [utg_pkg::LAT_W-1:0] lat;
        logic signed [utg_pkg::LON_W-1:0] lon;
        logic [utg_pkg::NORTH_W-1:0]      north;
        logic [utg_pkg::EAST_W-1:0]       east;
        int                               pick;
        pick  = $urandom_range(0, 99);
        north = utg_pkg::NORTH_W'($urandom_range(0, 24'hFFFFFF));
        if ($urandom_range(0, 9) < 7) begin
            lon = utg_pkg::LON_W'($urandom_range(0, 359999999) - 180000000);
        end else begin
            lon = utg_pkg::LON_W'($urandom);
        end
        if (pick < 8) begin
            lat = utg_pkg::LAT_W'($urandom_range(90000001, 134217727));
            if ($urandom_range(0, 1)) lat = -lat;
            if ($urandom_range(0, 9) == 0) lat = 28'sh8000000;
            east = utg_pkg::EAST_W'($urandom);
        end else begin
            lat = utg_pkg::LAT_W'($urandom_range(0, 180000000) - 90000000);
            if (pick < 16) begin
                if ($urandom_range(0, 1)) east = utg_pkg::EAST_W'($urandom_range(0, 99999));
                else east = utg_pkg::EAST_W'($urandom_range(1000000, 20'hFFFFF));
            end else begin
                do east = utg_pkg::EAST_W'($urandom);
                while ((int'(east) % 1000000) < 100000);
            end
        end
        send_position(lat, lon, north, east, ROW_PREDICT);
    endtask

    task automatic await_drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_chars.size() != 0) @(posedge aclk);
    endtask

    task automatic set_precision(input logic [utg_pkg::PREC_W-1:0] value);
        await_drain();
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        prec_mirror = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // output side: runs of steady ready, light and heavy stalls, rare long holds
    initial begin : sink_stall
        int mode, span;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(20, 120);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0: begin
                        m_tready = 1'b1;
                    end
                    1: begin
                        m_tready = ($urandom_range(0, 3) != 0);
                    end
                    2: begin
                        m_tready = $urandom_range(0, 1);
                    end
                    default: begin
                        if ($urandom_range(0, 19) == 0) begin
                            m_tready = 1'b0;
                            repeat ($urandom_range(10, 50)) @(negedge aclk);
                        end
                        m_tready = 1'b1;
                    end
                endcase
            end
        end
    end

    always @(posedge aclk) begin : check_chars
        grid_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                $error("unexpected transfer: char_code %h last %b status %0d",
                       m_tdata, m_tlast, m_tuser);
                fault_count++;
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata !== want.code) begin
                    $error("char_code expected %h actual %h", want.code, m_tdata);
                    fault_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_char expected %b actual %b", want.last, m_tlast);
                    fault_count++;
                end
                if (m_tuser !== want.status) begin
                    $error("status expected %0d actual %0d", want.status, m_tuser);
                    fault_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            send_position(DIRECTED_ROWS[i].lat, DIRECTED_ROWS[i].lon, DIRECTED_ROWS[i].north,
                          DIRECTED_ROWS[i].east, DIRECTED_ROWS[i].kind);
        end

        foreach (PREC_PLAN[p]) begin
            set_precision(PREC_PLAN[p]);
            sender_gaps = ($urandom_range(0, 3) != 0);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 39) == 0) await_drain();
                send_random_position();
            end
        end

        await_drain();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fault_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
